>>> hdl/ftxl_pkg.sv
package ftxl_pkg;

   localparam int unsigned WORD_W = 31;
   localparam int unsigned LAG_W = 14;
   localparam int unsigned LAG_SEL_W = 2;
   localparam int unsigned PROD_W = 46;
   localparam int unsigned DIV_CNT_W = 5;

   // request codes
   localparam logic REQ_RESEED = 1'b0;
   localparam logic REQ_DRAW = 1'b1;

   // Lehmer step over the Mersenne prime 2^31-1
   localparam logic [14:0] LEHMER_MULT = 15'd16807;
   localparam logic [WORD_W-1:0] LEHMER_MOD = 31'h7FFF_FFFF;

   // the four feedback lags
   localparam logic [LAG_W-1:0] LAG_A = 14'd471;
   localparam logic [LAG_W-1:0] LAG_B = 14'd1586;
   localparam logic [LAG_W-1:0] LAG_C = 14'd6988;
   localparam logic [LAG_W-1:0] LAG_D = 14'd9689;
   localparam logic [LAG_SEL_W-1:0] LAG_SEL_LAST = 2'd3;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = 5'd30;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL_MUL,
      ST_FILL_RED,
      ST_READ,
      ST_WRITE,
      ST_DIV
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   function automatic logic [LAG_W-1:0] lag_of(input logic [LAG_SEL_W-1:0] sel);
      logic [LAG_W-1:0] lag;
      unique case (sel)
         2'd0: lag = LAG_A;
         2'd1: lag = LAG_B;
         2'd2: lag = LAG_C;
         default: lag = LAG_D;
      endcase
      return lag;
   endfunction

endpackage

>>> hdl/ftxl_table.sv
module ftxl_table #(
   parameter int unsigned TABLE_DEPTH = 16384,
   parameter int unsigned IDX_W = 14
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [IDX_W-1:0]                 wr_addr,
   input  logic [ftxl_pkg::WORD_W-1:0]      wr_data,
   input  logic [IDX_W-1:0]                 rd_addr,
   output logic [ftxl_pkg::WORD_W-1:0]      rd_data
);

   logic [ftxl_pkg::WORD_W-1:0] mem [TABLE_DEPTH];
   logic [ftxl_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/ftxl_lehmer.sv
module ftxl_lehmer (
   input  logic                         clock,
   input  logic [ftxl_pkg::WORD_W-1:0]  x,
   output logic [ftxl_pkg::WORD_W-1:0]  x_next
);

   logic [ftxl_pkg::PROD_W-1:0] prod_ff;
   logic [ftxl_pkg::WORD_W:0]   fold;

   // registered product, then a combinational Mersenne fold
   always_ff @(posedge clock) begin
      prod_ff <= ftxl_pkg::PROD_W'(ftxl_pkg::LEHMER_MULT) * ftxl_pkg::PROD_W'(x);
   end

   always_comb begin
      fold = {1'b0, prod_ff[ftxl_pkg::WORD_W-1:0]}
           + (ftxl_pkg::WORD_W+1)'(prod_ff[ftxl_pkg::PROD_W-1:ftxl_pkg::WORD_W]);
      if (fold >= {1'b0, ftxl_pkg::LEHMER_MOD}) begin
         x_next = ftxl_pkg::WORD_W'(fold - {1'b0, ftxl_pkg::LEHMER_MOD});
      end else begin
         x_next = fold[ftxl_pkg::WORD_W-1:0];
      end
   end

endmodule

>>> hdl/ftxl_modulo.sv
module ftxl_modulo (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [ftxl_pkg::WORD_W-1:0]    dividend,
   input  logic [ftxl_pkg::WORD_W-1:0]    divisor,
   output ftxl_pkg::div_status_type       status,
   output logic [ftxl_pkg::WORD_W-1:0]    remainder
);

   logic                             busy_ff;
   logic                             done_ff;
   logic [ftxl_pkg::DIV_CNT_W-1:0]   cnt_ff;
   logic [ftxl_pkg::WORD_W-1:0]      dvd_ff;
   logic [ftxl_pkg::WORD_W-1:0]      n_ff;
   logic [ftxl_pkg::WORD_W-1:0]      rem_ff;
   logic [ftxl_pkg::WORD_W:0]        trial;
   logic [ftxl_pkg::WORD_W-1:0]      rem_in;

   // restoring step: one quotient bit a cycle
   always_comb begin
      trial = {rem_ff, dvd_ff[ftxl_pkg::WORD_W-1]};
      if (trial >= {1'b0, n_ff}) begin
         rem_in = ftxl_pkg::WORD_W'(trial - {1'b0, n_ff});
      end else begin
         rem_in = trial[ftxl_pkg::WORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == ftxl_pkg::DIV_LAST_STEP) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         n_ff   <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[ftxl_pkg::WORD_W-2:0], 1'b0};
         rem_ff <= rem_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign remainder   = rem_ff;

endmodule

>>> hdl/four_tap_xor_lagged_generator_core.sv
// Four-tap XOR lagged random generator (lags 471, 1586, 6988, 9689) over a
// table of TABLE_DEPTH 31-bit words held in one single-port-read memory.
// Channels: req_ beats carry req_type and req_modulus, rsp_ beats carry
// rsp_value_mod and rsp_raw_word; both use valid/stall. csr_ writes the seed
// register with valid/ready and is always ready.
// Reseed beat (req_type 0): fill the whole table with the Lehmer sequence of
// the seed via the multiply/fold unit (a multiply state, then a fold/write
// state per word); it stays busy until the table is full, returning no beat.
// Draw beat (req_type 1): 4 memory reads (one read port), one write-back and
// the bit-serial modulo unit; the result beat waits for the output register,
// and the next request can be taken in the same cycle as the result beat.
// One item is in flight at a time; req_stall is high while it is at work.
// An output register holds the result, so a new request is taken while the
// receiver stalls; a finished draw waits only if that register is still full.
// Reset: seed and write index clear and the table reads as all zero until the
// first reseed; no clearing pass is run.
module four_tap_xor_lagged_generator_core #(
   parameter int unsigned TABLE_DEPTH = 16384
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_type,
   input  logic [ftxl_pkg::WORD_W-1:0]   req_modulus,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ftxl_pkg::WORD_W-1:0]   rsp_value_mod,
   output logic [ftxl_pkg::WORD_W-1:0]   rsp_raw_word,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ftxl_pkg::WORD_W-1:0]   csr_seed_value
);

   localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);
   localparam logic [IDX_W:0] DEPTH_EXT = (IDX_W+1)'(TABLE_DEPTH);

   ftxl_pkg::state_type state_ff, state_in;

   logic [ftxl_pkg::WORD_W-1:0]     seed_ff;
   logic [IDX_W-1:0]                idx_ff;
   logic [IDX_W-1:0]                fill_addr_ff;
   logic [ftxl_pkg::LAG_SEL_W-1:0]  lag_sel_ff;
   logic                            rd_pend_ff;
   logic                            loaded_ff;
   logic [ftxl_pkg::WORD_W-1:0]     acc_ff;
   logic [ftxl_pkg::WORD_W-1:0]     x_ff;
   logic [ftxl_pkg::WORD_W-1:0]     modulus_ff;
   logic [ftxl_pkg::WORD_W-1:0]     word_ff;
   logic                            rsp_valid_ff;
   logic [ftxl_pkg::WORD_W-1:0]     rsp_value_mod_ff;
   logic [ftxl_pkg::WORD_W-1:0]     rsp_raw_word_ff;

   logic                            req_accept;
   logic                            out_free;
   logic                            mem_we;
   logic [IDX_W-1:0]                mem_waddr;
   logic [ftxl_pkg::WORD_W-1:0]     mem_wdata;
   logic [IDX_W-1:0]                mem_raddr;
   logic [ftxl_pkg::WORD_W-1:0]     mem_rdata;
   logic [ftxl_pkg::WORD_W-1:0]     tap_word;
   logic [ftxl_pkg::WORD_W-1:0]     new_word;
   logic [ftxl_pkg::WORD_W-1:0]     lehmer_word;
   logic                            div_start;
   logic                            rsp_load;
   ftxl_pkg::div_status_type        div_status;
   logic [ftxl_pkg::WORD_W-1:0]     div_rem;

   // position lag entries behind idx, wrapping at the table depth
   function automatic logic [IDX_W-1:0] lag_pos(input logic [IDX_W-1:0] idx,
                                                input logic [ftxl_pkg::LAG_W-1:0] lag);
      logic [IDX_W:0] lag_ext;
      logic [IDX_W:0] pos;
      lag_ext = (IDX_W+1)'(lag);
      if ({1'b0, idx} >= lag_ext) begin
         pos = {1'b0, idx} - lag_ext;
      end else begin
         pos = {1'b0, idx} + DEPTH_EXT - lag_ext;
      end
      return pos[IDX_W-1:0];
   endfunction

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ftxl_pkg::ST_IDLE);
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // table reads as zero until the first reseed has filled it
   assign tap_word = loaded_ff ? mem_rdata : '0;
   assign new_word = acc_ff ^ tap_word;

   ftxl_table #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX_W       (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   ftxl_lehmer u_lehmer (
      .clock  (clock),
      .x      (x_ff),
      .x_next (lehmer_word)
   );

   ftxl_modulo u_modulo (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (new_word),
      .divisor   (modulus_ff),
      .status    (div_status),
      .remainder (div_rem)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ftxl_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = (req_type == ftxl_pkg::REQ_DRAW) ? ftxl_pkg::ST_READ
                                                           : ftxl_pkg::ST_FILL_MUL;
            end
         end
         ftxl_pkg::ST_FILL_MUL: begin
            state_in = ftxl_pkg::ST_FILL_RED;
         end
         ftxl_pkg::ST_FILL_RED: begin
            state_in = (fill_addr_ff == IDX_LAST) ? ftxl_pkg::ST_IDLE
                                                  : ftxl_pkg::ST_FILL_MUL;
         end
         ftxl_pkg::ST_READ: begin
            if (lag_sel_ff == ftxl_pkg::LAG_SEL_LAST) begin
               state_in = ftxl_pkg::ST_WRITE;
            end
         end
         ftxl_pkg::ST_WRITE: begin
            state_in = ftxl_pkg::ST_DIV;
         end
         ftxl_pkg::ST_DIV: begin
            if (div_status.done && out_free) begin
               state_in = ftxl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ftxl_pkg::ST_IDLE;
         end
      endcase
   end

   // memory, divider and output-register controls
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = idx_ff;
      mem_wdata = new_word;
      mem_raddr = lag_pos(idx_ff, ftxl_pkg::lag_of(lag_sel_ff));
      div_start = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ftxl_pkg::ST_FILL_RED: begin
            mem_we    = 1'b1;
            mem_waddr = fill_addr_ff;
            mem_wdata = lehmer_word;
         end
         ftxl_pkg::ST_WRITE: begin
            mem_we    = 1'b1;
            div_start = 1'b1;
         end
         ftxl_pkg::ST_DIV: begin
            rsp_load = div_status.done && out_free;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ftxl_pkg::ST_IDLE;
         seed_ff      <= '0;
         idx_ff       <= '0;
         loaded_ff    <= 1'b0;
         rd_pend_ff   <= 1'b0;
         lag_sel_ff   <= '0;
         fill_addr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_pend_ff <= (state_ff == ftxl_pkg::ST_READ);
         if (csr_valid && csr_ready) begin
            seed_ff <= csr_seed_value;
         end
         if (req_accept) begin
            lag_sel_ff   <= '0;
            fill_addr_ff <= '0;
            // advance the write index on a draw; a reseed leaves it alone
            if (req_type == ftxl_pkg::REQ_DRAW) begin
               idx_ff <= (idx_ff == IDX_LAST) ? '0 : idx_ff + 1'b1;
            end
         end
         if (state_ff == ftxl_pkg::ST_READ) begin
            lag_sel_ff <= lag_sel_ff + 1'b1;
         end
         if (state_ff == ftxl_pkg::ST_FILL_RED) begin
            fill_addr_ff <= fill_addr_ff + 1'b1;
            if (fill_addr_ff == IDX_LAST) begin
               loaded_ff <= 1'b1;
            end
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         acc_ff     <= '0;
         modulus_ff <= req_modulus;
         x_ff       <= seed_ff;
      end else if ((state_ff == ftxl_pkg::ST_READ) && rd_pend_ff) begin
         acc_ff <= new_word;
      end
      if (state_ff == ftxl_pkg::ST_FILL_RED) begin
         x_ff <= lehmer_word;
      end
      if (state_ff == ftxl_pkg::ST_WRITE) begin
         word_ff <= new_word;
      end
      if (rsp_load) begin
         rsp_raw_word_ff  <= word_ff;
         // zero modulus passes the word through
         rsp_value_mod_ff <= (modulus_ff == '0) ? word_ff : div_rem;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_mod = rsp_value_mod_ff;
   assign rsp_raw_word  = rsp_raw_word_ff;

endmodule
